// ===== hw/rtl/salwc_pkg.sv =====
package salwc_pkg;
  localparam int MAX_SETS_DEF  = 256;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 32;
  localparam int CNT_W         = 32;
  localparam int CFG_W         = 4;
  localparam int RANK_W        = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
  localparam logic [3:0] OFFSET_MAX = 4'd12;
  localparam logic [3:0] INDEX_MAX  = 4'd8;

  typedef enum logic [1:0] {
    CMD_DREAD = 2'd0,
    CMD_DWRITE = 2'd1,
    CMD_IREAD = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_INDEX = 2'd1,
    REG_WAYS = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  // Result flags from the back end to the output stage
  typedef struct packed {
    logic       hit;
    logic       writeback;
    logic [2:0] way;
  } result_t;
endpackage

// ===== hw/rtl/salwc_front.sv =====
// Accepts accesses, splits the address into set and tag, pushes to a queue.
module salwc_front #(
  parameter int MAX_SETS  = salwc_pkg::MAX_SETS_DEF,
  parameter int ADDR_BITS = salwc_pkg::ADDR_BITS_DEF,
  parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int QW        = ADDR_BITS + SET_W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           offset_bits,
  input  logic [3:0]           index_bits,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [1:0]           command,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic [QW-1:0]        q_data
);
  import salwc_pkg::*;

  logic [3:0] ob, ib;
  logic [ADDR_BITS-1:0] shifted, tag, set_mask;
  logic [SET_W-1:0] set_idx;
  logic is_write;
  logic [QW-1:0] slot [2];
  logic [1:0] cnt;
  logic wp, rp;
  logic push, pop;

  always_comb begin
    ob = (offset_bits > OFFSET_MAX) ? OFFSET_MAX : offset_bits;
    ib = (index_bits > INDEX_MAX) ? INDEX_MAX : index_bits;
    shifted  = address >> ob;
    set_mask = ~({ADDR_BITS{1'b1}} << ib);
    set_idx  = SET_W'(shifted & set_mask);
    tag      = shifted >> ib;
    is_write = (command == CMD_DWRITE);
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = slot[rp];

  // Two-entry queue between classification and the set update
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= {is_write, set_idx, tag};
    end
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/salwc_back.sv =====
// Read-modify-write of one set: read cycle, then update and result.
module salwc_back #(
  parameter int MAX_SETS  = salwc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = salwc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = salwc_pkg::ADDR_BITS_DEF,
  parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int QW        = ADDR_BITS + SET_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              ways_used,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [QW-1:0]           q_data,
  output logic                    r_valid,
  input  logic                    r_ready,
  output salwc_pkg::result_t      r_res,
  output logic [31:0]             access_count,
  output logic [31:0]             hit_count,
  output logic [31:0]             miss_count,
  output logic [31:0]             writeback_count
);
  import salwc_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FILL_W = $clog2(MAX_WAYS + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_UPDATE, S_CLEAR} state_t;
  state_t state;

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic                 dirty;
    logic [RANK_W-1:0]    rank;
  } entry_t;

  entry_t mem [MAX_SETS][MAX_WAYS];
  entry_t row [MAX_WAYS];
  entry_t row_new [MAX_WAYS];
  logic [FILL_W-1:0] fill_cnt [MAX_SETS];
  logic [FILL_W-1:0] fill;
  logic [SET_W-1:0] clr_idx;

  logic [ADDR_BITS-1:0] tag;
  logic [SET_W-1:0] set_idx;
  logic is_write;

  logic [FILL_W-1:0] ways, live;
  logic hit, wb, full;
  logic [WAY_W-1:0] way, hit_way, victim;
  logic [RANK_W-1:0] old_rank;
  logic fresh;

  // Take the next access once the pending result leaves, at the latest on the same edge
  assign q_ready = (state == S_IDLE) && (!r_valid || r_ready);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  always_comb begin
    ways = (ways_used == 4'd0) ? FILL_W'(1) :
           ({28'd0, ways_used} > MAX_WAYS) ? FILL_W'(MAX_WAYS) : FILL_W'(ways_used);
    live = (fill < ways) ? fill : ways;
    full = (fill >= ways);
    hit = 1'b0;
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (FILL_W'(i) < live && row[i].tag == tag) begin
        hit = 1'b1;
        hit_way = WAY_W'(i);
      end
    end
    victim = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (FILL_W'(i) < ways && row[i].rank > row[victim].rank) victim = WAY_W'(i);
    end
    fresh = !hit && !full;
    way = hit ? hit_way : (full ? victim : WAY_W'(fill));
    wb = !hit && full && row[victim].dirty;
    old_rank = row[way].rank;
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_new[i] = row[i];
      if (FILL_W'(i) < (hit ? live : (full ? ways : fill + 1'b1)) &&
          WAY_W'(i) != way && (fresh || row[i].rank < old_rank) &&
          row[i].rank < RANK_MAX) begin
        row_new[i].rank = row[i].rank + 1'b1;
      end
    end
    row_new[way].rank = '0;
    if (hit) begin
      if (is_write) row_new[way].dirty = 1'b1;
    end else begin
      row_new[way].tag = tag;
      row_new[way].dirty = is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid && q_ready) begin
      {is_write, set_idx, tag} <= q_data;
    end
    if (state == S_READ) begin
      row <= mem[set_idx];
      fill <= fill_cnt[set_idx];
    end
    if (state == S_UPDATE) begin
      mem[set_idx] <= row_new;
      r_res <= '{hit: hit, writeback: wb, way: 3'(way)};
    end
    // Clear one fill count per cycle after reset
    if (state == S_CLEAR) begin
      fill_cnt[clr_idx] <= '0;
    end
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      r_valid <= 1'b0;
      access_count <= '0;
      hit_count <= '0;
      miss_count <= '0;
      writeback_count <= '0;
    end else begin
      if (r_valid && r_ready) r_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SET_W'(MAX_SETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid && q_ready) state <= S_READ;
        S_READ: state <= S_UPDATE;
        S_UPDATE: begin
          state <= S_IDLE;
          r_valid <= 1'b1;
          access_count <= sat_inc(access_count);
          if (hit) hit_count <= sat_inc(hit_count);
          else miss_count <= sat_inc(miss_count);
          if (wb) writeback_count <= sat_inc(writeback_count);
          if (fresh) fill_cnt[set_idx] <= fill + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/set_assoc_lru_writeback_cache_core.sv =====
// From input transfer to result valid an access passes the queue, the set read and the update.
// The back end takes a new access only when idle after its last update; a waiting
// result holds the back end, and the front queue keeps accepting up to two accesses.
// Reset (synchronous, rst high) clears counters and handshakes at once, then runs a
// clearing pass over the MAX_SETS (256) fill counts before the first set
// read. Registers return to offset 5, index 6, ways 4.
module set_assoc_lru_writeback_cache_core #(
  parameter int MAX_SETS  = salwc_pkg::MAX_SETS_DEF,
  parameter int MAX_WAYS  = salwc_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS = salwc_pkg::ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [3:0]             cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ADDR_BITS-1:0]   s_axis_tdata,  // address
  input  logic [1:0]             s_axis_tuser,  // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [135:0]           m_axis_tdata   // hit, writeback, way[3], 4 counters, pad
);
  import salwc_pkg::*;

  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int QW = ADDR_BITS + SET_W + 1;

  logic [3:0] offset_bits, index_bits, ways_used;
  logic q_valid, q_ready;
  logic [QW-1:0] q_data;
  result_t res;
  logic [31:0] acc_c, hit_c, miss_c, wb_c;

  // Hold configuration; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 4'd5;
      index_bits  <= 4'd6;
      ways_used   <= 4'd4;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_OFFSET: offset_bits <= cfg_data;
        REG_INDEX:  index_bits <= cfg_data;
        REG_WAYS:   ways_used <= cfg_data;
        default: ;
      endcase
    end
  end

  salwc_front #(.MAX_SETS(MAX_SETS), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk, .rst, .offset_bits, .index_bits,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .address(s_axis_tdata), .command(s_axis_tuser),
    .q_valid, .q_ready, .q_data
  );

  salwc_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk, .rst, .ways_used, .q_valid, .q_ready, .q_data,
    .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_res(res),
    .access_count(acc_c), .hit_count(hit_c), .miss_count(miss_c), .writeback_count(wb_c)
  );

  assign m_axis_tdata = {3'b000, wb_c, miss_c, hit_c, acc_c, res.way, res.writeback, res.hit};
endmodule

// ===== hw/rtl/salwc_checker.sv =====
module salwc_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_sum: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[36:5] != 32'hFFFFFFFF |->
    m_axis_tdata[68:37] + m_axis_tdata[100:69] == m_axis_tdata[36:5])
    else $error("hits plus misses differ from accesses");
  a_wbmiss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
    else $error("writeback on a hit");
endmodule

bind set_assoc_lru_writeback_cache_core salwc_checker u_chk (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
